// ----- hdl/pars_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Priority aging ready scheduler package
// Shared codes, widths and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pars_pkg;

    localparam int LEVEL_W  = 4;
    localparam int TASK_W   = 5;
    localparam int STATUS_W = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 4'd8;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_DISP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQ    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPRI = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

    typedef struct packed {
        logic load;
        logic decode;
        logic start1;
        logic start2;
        logic run;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_disp;
        logic cnt_zero;
        logic pass_done;
        logic found;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/priority_aging_ready_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Priority aging ready scheduler
// Multilevel ready queue with one-step aging on every dispatch.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with opcode, task_id and priority_req;
// each gives exactly one result on out_valid/out_ready with status,
// chosen_task and chosen_level. level_count is to be written through cfg_we
// only while the block is idle, which the block itself does not enforce;
// it then takes effect for the next request.
// One request is worked on at a time. A dispatch scans the W waiting tasks
// through a two-stage read pipeline on the order memory and the task memory,
// one task a cycle, once to choose and again to rewrite the order when a
// task was chosen; nothing is scanned when no task is waiting.
// A finished result waits in the output register; a new request is accepted
// meanwhile, and its result is held back until the register is taken.
// Reset empties all queues and sets level_count to eight. Task levels in
// memory are only read for tasks that are waiting, so no clearing pass runs.
// ----------------------------------------------------------------------------
module priority_aging_ready_scheduler
#(
    parameter int MAX_TASKS  = 32,
    parameter int MAX_LEVELS = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pars_pkg::LEVEL_W-1:0]      level_count,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [pars_pkg::TASK_W-1:0]       task_id,
    input  wire logic [pars_pkg::LEVEL_W-1:0]      priority_req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pars_pkg::STATUS_W-1:0]          status,
    output logic [pars_pkg::TASK_W-1:0]            chosen_task,
    output logic [pars_pkg::LEVEL_W-1:0]           chosen_level
);

    pars_pkg::cmd_t cmd;
    pars_pkg::sts_t sts;

    pars_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pars_datapath
    #(
        .MAX_TASKS  (MAX_TASKS),
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .level_count  (level_count),
        .opcode       (opcode),
        .task_id      (task_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_task  (chosen_task),
        .chosen_level (chosen_level)
    );

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Second request accepted while one is in progress.");

    a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.found)
        else $error("Dispatch committed without a chosen task.");

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != pars_pkg::ST_DISP)) |->
        ((chosen_task == '0) && (chosen_level == '0)))
        else $error("Non-dispatch result carries a task or level.");

endmodule
`default_nettype wire

// ----- hdl/pars_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Priority aging ready scheduler controller
// Sequences decode, the search pass, the rewrite pass and result hand-off.
// ----------------------------------------------------------------------------
module pars_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pars_pkg::sts_t sts,
    output pars_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_P1   = 3'd2;
    localparam logic [2:0] S_P2   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decode = 1'b1;
                if (sts.is_disp && !sts.cnt_zero)
                begin
                    cmd.start1 = 1'b1;
                    state_next = S_P1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_P1:
            begin
                cmd.run = 1'b1;
                if (sts.pass_done)
                begin
                    if (sts.found)
                    begin
                        cmd.start2 = 1'b1;
                        state_next = S_P2;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_P2:
            begin
                cmd.run = 1'b1;
                if (sts.pass_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pars_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Priority aging ready scheduler datapath
// Holds the global wait order in two banks, per-task level and fresh mark,
// the waiting flags, the scan pipeline and the result register.
// ----------------------------------------------------------------------------
module pars_datapath
#(
    parameter int MAX_TASKS  = 32,
    parameter int MAX_LEVELS = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pars_pkg::cmd_t                    cmd,
    output pars_pkg::sts_t                         sts,
    input  wire logic                              cfg_we,
    input  wire logic [pars_pkg::LEVEL_W-1:0]      level_count,
    input  wire logic                              opcode,
    input  wire logic [pars_pkg::TASK_W-1:0]       task_id,
    input  wire logic [pars_pkg::LEVEL_W-1:0]      priority_req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pars_pkg::STATUS_W-1:0]          status,
    output logic [pars_pkg::TASK_W-1:0]            chosen_task,
    output logic [pars_pkg::LEVEL_W-1:0]           chosen_level
);

    localparam int LW  = pars_pkg::LEVEL_W;
    localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int AW  = $clog2(2 * MAX_TASKS);
    localparam int TMW = LW + 1;
    localparam logic [AW-1:0] BANK_OFF = AW'(MAX_TASKS);
    localparam logic [LW:0]   MAXL     = (LW+1)'(MAX_LEVELS);

    logic [TW-1:0]  ord_mem [0:2*MAX_TASKS-1];
    logic [TMW-1:0] tm_mem  [0:MAX_TASKS-1];

    logic [LW-1:0]               lc_reg;
    logic                        op_reg;
    logic [pars_pkg::TASK_W-1:0] tid_reg;
    logic [LW-1:0]               pri_reg;
    logic [MAX_TASKS-1:0]        waiting_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        bank_reg;
    logic                        mode_reg;
    logic [CW-1:0]               rd_idx_reg;
    logic                        s1_vld_reg;
    logic [TW-1:0]               ord_rd_reg;
    logic                        s2_vld_reg;
    logic [TW-1:0]               s2_tid_reg;
    logic [TMW-1:0]              tm_rd_reg;
    logic                        found_reg;
    logic [TW-1:0]               best_tid_reg;
    logic [LW-1:0]               best_lev_reg;
    logic                        best_mv_reg;
    logic [CW-1:0]               mcnt_reg;
    logic [CW-1:0]               wi_reg;
    logic [CW-1:0]               wj_reg;
    logic [pars_pkg::STATUS_W-1:0] res_status_reg;
    logic [pars_pkg::TASK_W-1:0]   res_task_reg;
    logic [LW-1:0]                 res_lev_reg;
    logic                          out_valid_reg;
    logic [pars_pkg::STATUS_W-1:0] out_status_reg;
    logic [pars_pkg::TASK_W-1:0]   out_task_reg;
    logic [LW-1:0]                 out_lev_reg;

    logic [LW-1:0]                 eff_lv;
    logic                          tid_ok;
    logic [TW-1:0]                 tid_idx;
    logic                          pri_ok;
    logic [pars_pkg::STATUS_W-1:0] enq_status;
    logic                          enq_go;
    logic [LW-1:0]                 s2_lev;
    logic                          s2_fr;
    logic                          s2_inr;
    logic                          s2_mv;
    logic [LW-1:0]                 s2_new;
    logic                          s2_better;
    logic                          p2_wr;
    logic                          issue;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 cur_base;
    logic [AW-1:0]                 oth_base;
    logic                          ord_we;
    logic [AW-1:0]                 ord_waddr;
    logic [TW-1:0]                 ord_wdata;
    logic [TW-1:0]                 tm_waddr;
    logic [TMW-1:0]                tm_wdata;

    always_comb
    begin
        if (lc_reg == '0)
        begin
            eff_lv = LW'(1);
        end
        else if ({1'b0, lc_reg} > MAXL)
        begin
            eff_lv = LW'(MAX_LEVELS);
        end
        else
        begin
            eff_lv = lc_reg;
        end
    end

    assign tid_ok  = (32'(tid_reg) < 32'(MAX_TASKS));
    assign tid_idx = TW'(tid_reg);
    assign pri_ok  = (pri_reg != '0) && (pri_reg <= eff_lv);

    always_comb
    begin
        if (!pri_ok || !tid_ok)
        begin
            enq_status = pars_pkg::ST_BADPRI;
        end
        else if (waiting_reg[tid_idx])
        begin
            enq_status = pars_pkg::ST_DUP;
        end
        else
        begin
            enq_status = pars_pkg::ST_ENQ;
        end
    end

    assign enq_go = cmd.decode && (op_reg == pars_pkg::OP_ENQ) &&
                    (enq_status == pars_pkg::ST_ENQ);

    // A waiting task that is not fresh and sits on levels 2 up to the level
    // count moves one level up; movers go behind everything else in order.
    assign s2_lev    = tm_rd_reg[LW-1:0];
    assign s2_fr     = tm_rd_reg[LW];
    assign s2_inr    = (s2_lev <= eff_lv);
    assign s2_mv     = s2_inr && !s2_fr && (s2_lev >= LW'(2));
    assign s2_new    = s2_lev - LW'(s2_mv);
    assign s2_better = s2_inr && (!found_reg || (s2_new < best_lev_reg) ||
                       ((s2_new == best_lev_reg) && best_mv_reg && !s2_mv));
    assign p2_wr     = s2_vld_reg && mode_reg && (s2_tid_reg != best_tid_reg);

    assign issue    = cmd.run && (rd_idx_reg < cnt_reg);
    assign cur_base = bank_reg ? BANK_OFF : '0;
    assign oth_base = bank_reg ? '0 : BANK_OFF;
    assign rd_addr  = cur_base + AW'(rd_idx_reg);

    assign ord_we    = enq_go || p2_wr;
    assign ord_waddr = enq_go ? (cur_base + AW'(cnt_reg))
                              : (oth_base + AW'(s2_mv ? wj_reg : wi_reg));
    assign ord_wdata = enq_go ? tid_idx : s2_tid_reg;
    assign tm_waddr  = enq_go ? tid_idx : s2_tid_reg;
    assign tm_wdata  = enq_go ? {1'b1, pri_reg} : {(s2_inr ? 1'b0 : s2_fr), s2_new};

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (issue)
        begin
            ord_rd_reg <= ord_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            tm_mem[tm_waddr] <= tm_wdata;
        end
        if (s1_vld_reg)
        begin
            tm_rd_reg  <= tm_mem[ord_rd_reg];
            s2_tid_reg <= ord_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            tid_reg <= task_id;
            pri_reg <= priority_req;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_task_reg   <= res_task_reg;
            out_lev_reg    <= res_lev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg         <= pars_pkg::LEVEL_COUNT_RESET;
            waiting_reg    <= '0;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            mode_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            best_tid_reg   <= '0;
            best_lev_reg   <= '0;
            best_mv_reg    <= 1'b0;
            mcnt_reg       <= '0;
            wi_reg         <= '0;
            wj_reg         <= '0;
            res_status_reg <= pars_pkg::ST_NONE;
            res_task_reg   <= '0;
            res_lev_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lc_reg <= level_count;
            end

            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;

            if (cmd.start1 || cmd.start2)
            begin
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end

            if (cmd.start1)
            begin
                mode_reg  <= 1'b0;
                found_reg <= 1'b0;
                mcnt_reg  <= '0;
            end
            else if (s2_vld_reg && !mode_reg)
            begin
                if (s2_better)
                begin
                    found_reg    <= 1'b1;
                    best_tid_reg <= s2_tid_reg;
                    best_lev_reg <= s2_new;
                    best_mv_reg  <= s2_mv;
                end
                if (s2_mv)
                begin
                    mcnt_reg <= mcnt_reg + CW'(1);
                end
            end

            if (cmd.start2)
            begin
                mode_reg <= 1'b1;
                wi_reg   <= '0;
                wj_reg   <= cnt_reg - CW'(1) - mcnt_reg + CW'(best_mv_reg);
            end
            else if (p2_wr)
            begin
                if (s2_mv)
                begin
                    wj_reg <= wj_reg + CW'(1);
                end
                else
                begin
                    wi_reg <= wi_reg + CW'(1);
                end
            end

            if (cmd.decode)
            begin
                res_status_reg <= (op_reg == pars_pkg::OP_ENQ) ? enq_status
                                                               : pars_pkg::ST_NONE;
                res_task_reg   <= '0;
                res_lev_reg    <= '0;
            end

            if (enq_go)
            begin
                waiting_reg[tid_idx] <= 1'b1;
                cnt_reg              <= cnt_reg + CW'(1);
            end

            if (cmd.commit)
            begin
                waiting_reg[best_tid_reg] <= 1'b0;
                cnt_reg        <= cnt_reg - CW'(1);
                bank_reg       <= !bank_reg;
                res_status_reg <= pars_pkg::ST_DISP;
                res_task_reg   <= pars_pkg::TASK_W'(best_tid_reg);
                res_lev_reg    <= best_lev_reg;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_disp   = (op_reg == pars_pkg::OP_DISP);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.pass_done = (rd_idx_reg == cnt_reg) && !s1_vld_reg && !s2_vld_reg;
    assign sts.found     = found_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign chosen_task  = out_task_reg;
    assign chosen_level = out_lev_reg;

endmodule
`default_nettype wire

// ----- bench/priority_aging_ready_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority aging ready scheduler testbench
// Drives enqueue and dispatch requests through bursty valid/ready traffic,
// predicts every result with an independent ready-queue model and compares
// status, chosen task and chosen level in order. Several level counts are
// used, including the extremes and out-of-range values.
// ----------------------------------------------------------------------------
module priority_aging_ready_scheduler_tb;

    localparam int NTASK = 32;
    localparam int NLVL  = 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_CYCLES = 1500;

    typedef struct packed {
        logic                          op;
        logic [pars_pkg::TASK_W-1:0]   tid;
        logic [pars_pkg::LEVEL_W-1:0]  pri;
    } request_t;

    typedef struct packed {
        logic [pars_pkg::STATUS_W-1:0] st;
        logic [pars_pkg::TASK_W-1:0]   task_no;
        logic [pars_pkg::LEVEL_W-1:0]  lvl;
    } outcome_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pars_pkg::LEVEL_W-1:0]  level_count;
    logic                          in_valid;
    logic                          in_ready;
    logic                          opcode;
    logic [pars_pkg::TASK_W-1:0]   task_id;
    logic [pars_pkg::LEVEL_W-1:0]  priority_req;
    logic                          out_valid;
    logic                          out_ready;
    logic [pars_pkg::STATUS_W-1:0] status;
    logic [pars_pkg::TASK_W-1:0]   chosen_task;
    logic [pars_pkg::LEVEL_W-1:0]  chosen_level;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];

    // Model of the ready queues: an ordered list of task slots per level.
    int          ready_list[NLVL+1][$];
    bit          is_fresh[NTASK];
    bit          is_waiting[NTASK];
    logic [3:0]  model_count;

    int  mismatches;
    int  results_seen;
    int  dispatched_seen;
    int  cycles;
    bit  hold_req;
    bit  hold_used;
    int  hold_cnt;
    logic hold_off;
    int  burst_left;
    int  gap_left;
    int  stall_pat;

    priority_aging_ready_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .level_count  (level_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .task_id      (task_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_task  (chosen_task),
        .chosen_level (chosen_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    assign hold_off = (hold_cnt > 0);

    function automatic int active_levels();
        if (model_count == 0)
            return 1;
        if (model_count > NLVL)
            return NLVL;
        return model_count;
    endfunction

    function automatic outcome_t schedule_request(request_t r);
        outcome_t o;
        int       lv;
        int       top;
        int       n;
        int       t;
        int       kept[$];
        o = '0;
        n = active_levels();
        if (r.op == pars_pkg::OP_ENQ)
        begin
            if (r.pri < 1 || r.pri > n)
            begin
                o.st = pars_pkg::ST_BADPRI;
            end
            else if (is_waiting[r.tid])
            begin
                o.st = pars_pkg::ST_DUP;
            end
            else
            begin
                is_waiting[r.tid] = 1'b1;
                is_fresh[r.tid]   = 1'b1;
                ready_list[r.pri].push_back(r.tid);
                o.st = pars_pkg::ST_ENQ;
            end
            return o;
        end
        top = 0;
        for (lv = 1; lv <= n; lv++)
            if (top == 0 && ready_list[lv].size() > 0)
                top = lv;
        if (top == 0)
        begin
            o.st = pars_pkg::ST_NONE;
            return o;
        end
        for (lv = 2; lv <= n; lv++)
        begin
            kept.delete();
            foreach (ready_list[lv][k])
            begin
                if (is_fresh[ready_list[lv][k]])
                    kept.push_back(ready_list[lv][k]);
                else
                    ready_list[lv-1].push_back(ready_list[lv][k]);
            end
            ready_list[lv] = kept;
        end
        top = 0;
        for (lv = 1; lv <= n; lv++)
            if (top == 0 && ready_list[lv].size() > 0)
                top = lv;
        t = ready_list[top].pop_front();
        is_waiting[t] = 1'b0;
        is_fresh[t]   = 1'b0;
        for (lv = 1; lv <= n; lv++)
            foreach (ready_list[lv][k])
                is_fresh[ready_list[lv][k]] = 1'b0;
        o.st      = pars_pkg::ST_DISP;
        o.task_no = t[pars_pkg::TASK_W-1:0];
        o.lvl     = top[pars_pkg::LEVEL_W-1:0];
        return o;
    endfunction

    function automatic request_t make_req(logic op, int tid, int pri);
        request_t r;
        r.op  = op;
        r.tid = tid[pars_pkg::TASK_W-1:0];
        r.pri = pri[pars_pkg::LEVEL_W-1:0];
        return r;
    endfunction

    // Dispatches and mostly valid enqueues from a slot pool of 8 or 32, so duplicates and aging occur.
    function automatic request_t random_req(int pool);
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return make_req(pars_pkg::OP_DISP, $urandom, $urandom);
        if (k < 90)
            return make_req(pars_pkg::OP_ENQ, $urandom_range(0, pool - 1),
                            $urandom_range(1, active_levels()));
        return make_req(pars_pkg::OP_ENQ, $urandom, $urandom);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_level_count(int v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        level_count <= v[pars_pkg::LEVEL_W-1:0];
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_count = v[3:0];
    endtask

    // Driver: bursts of offers with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            opcode       <= pars_pkg::OP_ENQ;
            task_id      <= '0;
            priority_req <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_outcomes.push_back(schedule_request(pending_reqs.pop_front()));
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    request_t r;
                    r = pending_reqs[0];
                    in_valid     <= 1'b1;
                    opcode       <= r.op;
                    task_id      <= r.tid;
                    priority_req <= r.pri;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                  : $urandom_range(0, 60);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req && !hold_used)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycles          <= 0;
            stall_pat       <= 0;
            out_ready       <= 1'b0;
            mismatches      <= 0;
            results_seen    <= 0;
            dispatched_seen <= 0;
        end
        else
        begin
            cycles    <= cycles + 1;
            stall_pat <= stall_pat + 1;
            out_ready <= !hold_off && ((stall_pat % 97) > 40 || $urandom_range(0, 3) != 0);
            if (out_valid && out_ready)
            begin
                outcome_t e;
                results_seen <= results_seen + 1;
                if (expected_outcomes.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected result: status %0d task %0d level %0d",
                                 status, chosen_task, chosen_level);
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    if (e.st == pars_pkg::ST_DISP)
                        dispatched_seen <= dispatched_seen + 1;
                    if (e.st !== status || e.task_no !== chosen_task
                        || e.lvl !== chosen_level)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     e.st, e.task_no, e.lvl,
                                     status, chosen_task, chosen_level);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("priority_aging_ready_scheduler_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int counts[$];
        int i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        level_count = pars_pkg::LEVEL_COUNT_RESET;
        hold_req = 1'b0;
        model_count = pars_pkg::LEVEL_COUNT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed requests at the reset level count.
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 0, 0));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 31, 9));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 31, 15));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 31, 8));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 31, 8));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 0, 1));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 21, 5));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 10, 1));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 31, 15));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 5, 8));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 7, 3));
        wait_idle();

        // Lowering the count strands tasks on the upper levels.
        write_level_count(2);
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 31, 3));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 7, 2));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 14, 2));
        for (i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        wait_idle();
        write_level_count(0);
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 3, 2));
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 3, 1));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        wait_idle();
        write_level_count(15);
        pending_reqs.push_back(make_req(pars_pkg::OP_ENQ, 9, 9));
        pending_reqs.push_back(make_req(pars_pkg::OP_DISP, 0, 0));
        wait_idle();

        // Random phases over several level counts; one long receiver hold-off.
        counts = '{8, 1, 4, 0, 12, 3, 8};
        foreach (counts[c])
        begin
            write_level_count(counts[c]);
            for (i = 0; i < 130; i++)
                pending_reqs.push_back(random_req(($urandom_range(0, 1) == 1) ? 8 : 32));
            if (c == 2)
                hold_req = 1'b1;
            wait_idle();
        end

        $display("Covered %0d results, %0d of them dispatches, over level counts 0 to 15.",
                 results_seen, dispatched_seen);
        if (mismatches == 0)
            $display("priority_aging_ready_scheduler_tb passed");
        else
            $display("priority_aging_ready_scheduler_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pars_pkg.sv
hdl/pars_ctrl.sv
hdl/pars_datapath.sv
hdl/priority_aging_ready_scheduler.sv
bench/priority_aging_ready_scheduler_tb.sv
